/* hdl/triangle_face_normal_defines.svh */
// Assertion macros shared by the triangle face normal RTL
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define TFN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("tfn assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("tfn assertion failed");
`else
`define TFN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tfn_pkg.sv */
// Shared constants and types of the triangle face normal block
package tfn_pkg;
	localparam int unsigned VERTEX_DEPTH_DEF = 256;

	// field widths
	localparam int POS_W  = 16;
	localparam int SLOT_W = 8;
	localparam int NRM_W  = 16;

	// command codes
	localparam logic CMD_STORE    = 1'b0;
	localparam logic CMD_TRIANGLE = 1'b1;

	// datapath widths
	localparam int DIFF_W    = POS_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int LEAD_W    = $clog2(CROSS_W);
	localparam int NORM_W    = 31;
	localparam int SQ_W      = 2 * NORM_W;
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int Q14_SHIFT = 14;
	localparam int QUO_W     = Q14_SHIFT + 1;
	localparam int REM_W     = NORM_W + Q14_SHIFT + 2;

	// per-item status carried next to the normalized magnitudes
	typedef struct packed {
		logic       degenerate;
		logic [2:0] neg;
	} nrm_tag_t;
endpackage

/* hdl/tfn_if.sv */
// Request and response channel interfaces of the triangle face normal block
interface tfn_req_if;
	import tfn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic [SLOT_W-1:0]       vertex_slot;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [SLOT_W-1:0]       first_corner;
	logic [SLOT_W-1:0]       second_corner;
	logic [SLOT_W-1:0]       third_corner;

	modport source (output valid, cmd, vertex_slot, pos_x, pos_y, pos_z,
		first_corner, second_corner, third_corner, input ready);
	modport sink (input valid, cmd, vertex_slot, pos_x, pos_y, pos_z,
		first_corner, second_corner, third_corner, output ready);
endinterface

interface tfn_rsp_if;
	import tfn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic                    degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

/* hdl/tfn_ram.sv */
// Generic single-write, single-read RAM with registered read data
module tfn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hdl/tfn_cross.sv */
// Edge vectors and exact integer cross product, three stages
module tfn_cross (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                valid_in,
	input  logic [2:0][tfn_pkg::POS_W-1:0]      pa,
	input  logic [2:0][tfn_pkg::POS_W-1:0]      pb,
	input  logic [2:0][tfn_pkg::POS_W-1:0]      pc,
	output logic                                valid_out,
	output logic [2:0][tfn_pkg::CROSS_W-1:0]    mag,
	output logic [2:0]                          neg
);
	import tfn_pkg::*;

	logic signed [DIFF_W-1:0]  u_s1 [3];
	logic signed [DIFF_W-1:0]  v_s1 [3];
	logic signed [PROD_W-1:0]  p_s2 [3];
	logic signed [PROD_W-1:0]  q_s2 [3];
	logic signed [CROSS_W-1:0] cr   [3];
	logic                      vld_s1, vld_s2, vld_s3;
	logic [2:0][CROSS_W-1:0]   mag_s3;
	logic [2:0]                neg_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= valid_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: edge vectors b - a and c - a
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i] <= $signed({pb[i][POS_W-1], pb[i]}) - $signed({pa[i][POS_W-1], pa[i]});
				v_s1[i] <= $signed({pc[i][POS_W-1], pc[i]}) - $signed({pa[i][POS_W-1], pa[i]});
			end
		end
	end

	// stage 2: the six partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= u_s1[1] * v_s1[2];
			q_s2[0] <= u_s1[2] * v_s1[1];
			p_s2[1] <= u_s1[2] * v_s1[0];
			q_s2[1] <= u_s1[0] * v_s1[2];
			p_s2[2] <= u_s1[0] * v_s1[1];
			q_s2[2] <= u_s1[1] * v_s1[0];
		end
	end

	// stage 3: cross components split into sign and magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = CROSS_W'(p_s2[i]) - CROSS_W'(q_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= cr[i][CROSS_W-1];
				mag_s3[i] <= cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
			end
		end
	end

	assign valid_out = vld_s3;
	assign mag       = mag_s3;
	assign neg       = neg_s3;
endmodule

/* hdl/tfn_scale.sv */
// Block normalization of the cross product and sum of squares, four stages
module tfn_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               valid_in,
	input  logic [2:0][tfn_pkg::CROSS_W-1:0]   mag,
	input  logic [2:0]                         neg,
	output logic                               valid_out,
	output logic [2:0][tfn_pkg::NORM_W-1:0]    nmag,
	output logic [tfn_pkg::SUM_W-1:0]          sum,
	output tfn_pkg::nrm_tag_t                  tag
);
	import tfn_pkg::*;

	localparam logic [LEAD_W-1:0] NORM_TOP = LEAD_W'(NORM_W - 1);

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic [CROSS_W-1:0]     or_v;
	logic [LEAD_W-1:0]      lead;
	logic [2:0][CROSS_W-1:0] mag_s1;
	logic [LEAD_W-1:0]      lead_s1;
	nrm_tag_t               tag_s1, tag_s2, tag_s3, tag_s4;
	logic [2:0][NORM_W-1:0] nm;
	logic [2:0][NORM_W-1:0] nm_s2, nm_s3, nm_s4;
	logic [2:0][SQ_W-1:0]   sq_s3;
	logic [SUM_W-1:0]       sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= valid_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: leading one of the largest magnitude
	always_comb begin
		or_v = mag[0] | mag[1] | mag[2];
		lead = '0;
		for (int b = 0; b < CROSS_W; b++) begin
			if (or_v[b]) begin
				lead = LEAD_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1            <= mag;
			lead_s1           <= lead;
			tag_s1.neg        <= neg;
			tag_s1.degenerate <= (or_v == '0);
		end
	end

	// stage 2: common shift so the largest lands in [2^30, 2^31)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lead_s1 >= NORM_TOP) begin
				nm[i] = NORM_W'(mag_s1[i] >> (lead_s1 - NORM_TOP));
			end else begin
				nm[i] = NORM_W'(mag_s1[i] << (NORM_TOP - lead_s1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s2  <= nm;
			tag_s2 <= tag_s1;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= SQ_W'(nm_s2[i]) * SQ_W'(nm_s2[i]);
			end
			nm_s3  <= nm_s2;
			tag_s3 <= tag_s2;
		end
	end

	// stage 4: sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			nm_s4  <= nm_s3;
			tag_s4 <= tag_s3;
		end
	end

	assign valid_out = vld_s4;
	assign nmag      = nm_s4;
	assign sum       = sum_s4;
	assign tag       = tag_s4;
endmodule

/* hdl/tfn_sqrt.sv */
// Pipelined integer square root, one result bit per stage
module tfn_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         valid_in,
	input  logic [tfn_pkg::SUM_W-1:0]    radicand,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         valid_out,
	output logic [tfn_pkg::ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]            side_out
);
	import tfn_pkg::*;

	logic [SUM_W-1:0]  rem_q  [ROOT_W];
	logic [SUM_W-1:0]  res_q  [ROOT_W];
	logic              vld_q  [ROOT_W];
	logic [SIDE_W-1:0] side_q [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);

		logic [SUM_W-1:0]  rem_in, res_in, rem_nx, res_nx;
		logic [SUM_W:0]    trial;
		logic              vld_in;
		logic [SIDE_W-1:0] sd_in;

		if (k == 0) begin : g_head
			assign rem_in = radicand;
			assign res_in = '0;
			assign vld_in = valid_in;
			assign sd_in  = side_in;
		end else begin : g_body
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
			assign vld_in = vld_q[k-1];
			assign sd_in  = side_q[k-1];
		end

		// one restoring step of the digit-by-digit root
		always_comb begin
			trial = {1'b0, res_in} + {1'b0, BIT};
			if ({1'b0, rem_in} >= trial) begin
				rem_nx = rem_in - SUM_W'(trial);
				res_nx = (res_in >> 1) + BIT;
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k]  <= rem_nx;
				res_q[k]  <= res_nx;
				side_q[k] <= sd_in;
			end
		end
	end

	assign valid_out = vld_q[ROOT_W-1];
	assign root      = res_q[ROOT_W-1][ROOT_W-1:0];
	assign side_out  = side_q[ROOT_W-1];
endmodule

/* hdl/tfn_div.sv */
// Three-lane pipelined divider: rounded component over length, then signs
`include "triangle_face_normal_defines.svh"
module tfn_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 valid_in,
	input  logic [2:0][tfn_pkg::NORM_W-1:0]      nmag,
	input  logic [tfn_pkg::ROOT_W-1:0]           root,
	input  tfn_pkg::nrm_tag_t                    tag,
	output logic                                 valid_out,
	output logic [2:0][tfn_pkg::NRM_W-1:0]       nrm,
	output logic                                 degenerate
);
	import tfn_pkg::*;

	logic [2:0][REM_W-1:0] rem_q [QUO_W];
	logic [2:0][QUO_W-1:0] quo_q [QUO_W];
	logic [ROOT_W-1:0]     den_q [QUO_W];
	nrm_tag_t              tag_q [QUO_W];
	logic                  vld_q [QUO_W];

	logic                  vld_sf;
	logic [2:0][NRM_W-1:0] nrm_sf;
	logic                  deg_sf;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;

		logic [2:0][REM_W-1:0] rem_in, rem_nx;
		logic [2:0][QUO_W-1:0] quo_in, quo_nx;
		logic [ROOT_W-1:0]     den_in;
		logic [REM_W-1:0]      dsh;
		nrm_tag_t              tg_in;
		logic                  vld_in;

		if (k == 0) begin : g_head
			// numerator: magnitude in Q14 plus half the length for rounding
			for (genvar l = 0; l < 3; l++) begin : g_num
				assign rem_in[l] = (REM_W'(nmag[l]) << Q14_SHIFT) + REM_W'(root >> 1);
			end
			assign quo_in = '0;
			assign den_in = root;
			assign tg_in  = tag;
			assign vld_in = valid_in;
		end else begin : g_body
			assign rem_in = rem_q[k-1];
			assign quo_in = quo_q[k-1];
			assign den_in = den_q[k-1];
			assign tg_in  = tag_q[k-1];
			assign vld_in = vld_q[k-1];
		end

		// one quotient bit per lane
		always_comb begin
			dsh = REM_W'(den_in) << B;
			for (int l = 0; l < 3; l++) begin
				if (rem_in[l] >= dsh) begin
					rem_nx[l] = rem_in[l] - dsh;
					quo_nx[l] = quo_in[l] | (QUO_W'(1) << B);
				end else begin
					rem_nx[l] = rem_in[l];
					quo_nx[l] = quo_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k] <= rem_nx;
				quo_q[k] <= quo_nx;
				den_q[k] <= den_in;
				tag_q[k] <= tg_in;
			end
		end
	end

	// final stage: put signs back, zero vector when degenerate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (adv) begin
			vld_sf <= vld_q[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_sf <= tag_q[QUO_W-1].degenerate;
			for (int l = 0; l < 3; l++) begin
				if (tag_q[QUO_W-1].degenerate) begin
					nrm_sf[l] <= '0;
				end else if (tag_q[QUO_W-1].neg[l]) begin
					nrm_sf[l] <= NRM_W'(-NRM_W'(quo_q[QUO_W-1][l]));
				end else begin
					nrm_sf[l] <= NRM_W'(quo_q[QUO_W-1][l]);
				end
			end
		end
	end

	assign valid_out  = vld_sf;
	assign nrm        = nrm_sf;
	assign degenerate = deg_sf;

	// a unit normal never exceeds one in any component
	`TFN_ASSERT_IMP(a_div_bound, clk, arst_n, vld_sf, ($signed(nrm_sf[0]) <= 16384) && ($signed(nrm_sf[0]) >= -16384) && ($signed(nrm_sf[1]) <= 16384) && ($signed(nrm_sf[1]) >= -16384) && ($signed(nrm_sf[2]) <= 16384) && ($signed(nrm_sf[2]) >= -16384))
endmodule

/* hdl/triangle_face_normal.sv */
// Triangle face normal: vertex table, cross product, fixed-point normalization.
// A store beat writes one Q8.8 position into the vertex table and gives no
// result; a triangle beat reads its three corners and gives the unit face
// normal in Q1.14, or a zero vector with degenerate set when the cross product
// is zero. One beat is taken every cycle except while a stalled output holds
// the pipeline. Its stages are the registered table read (1), the cross product
// (3), normalization and sum of squares (4), the square root at one bit per
// stage (32), the three-lane divider at one quotient bit per stage plus sign
// stage (16) and the output register (1). A stalled output holds the pipeline,
// and the input, only once the last divider stage carries a result; until then
// the stages behind it keep moving and empty slots are squeezed out. The table
// is three copies of a 48-bit memory, one per corner read port; a store is
// visible to a triangle beat in the very next cycle. Corners at or beyond
// VERTEX_DEPTH read as the origin, stores there are dropped, and reading a
// never-written entry gives an unspecified normal.
`include "triangle_face_normal_defines.svh"
module triangle_face_normal #(
	parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tfn_req_if.sink    req,
	tfn_rsp_if.source  rsp
);
	import tfn_pkg::*;

	localparam int AW    = $clog2(VERTEX_DEPTH);
	localparam int VTX_W = 3 * POS_W;
	localparam int SIDE_W = 3 * NORM_W + $bits(nrm_tag_t);

	logic                   adv, load, acc;
	logic                   wr_en;
	logic [VTX_W-1:0]       wr_data;
	logic [AW-1:0]          wr_addr;
	logic [2:0][SLOT_W-1:0] corner;
	logic [2:0][VTX_W-1:0]  rd_data;
	logic                   vld_s1;
	logic [2:0]             oor_s1;
	logic [2:0][2:0][POS_W-1:0] pos;

	logic                   cr_vld;
	logic [2:0][CROSS_W-1:0] cr_mag;
	logic [2:0]             cr_neg;
	logic                   sc_vld;
	logic [2:0][NORM_W-1:0] sc_nmag;
	logic [SUM_W-1:0]       sc_sum;
	nrm_tag_t               sc_tag;
	logic                   sq_vld;
	logic [ROOT_W-1:0]      sq_root;
	logic [SIDE_W-1:0]      sq_side;
	logic [2:0][NORM_W-1:0] sq_nmag;
	nrm_tag_t               sq_tag;
	logic                   dv_vld;
	logic [2:0][NRM_W-1:0]  dv_nrm;
	logic                   dv_deg;

	logic                   out_vld_q;
	logic [2:0][NRM_W-1:0]  out_nrm_q;
	logic                   out_deg_q;

	// pipeline moves when the output register frees up or the last slot is empty
	assign load      = !out_vld_q || rsp.ready;
	assign adv       = load || !dv_vld;
	assign req.ready = adv;
	assign acc       = req.valid && adv;

	// vertex table writes
	assign wr_en   = acc && (req.cmd == CMD_STORE) && (32'(req.vertex_slot) < VERTEX_DEPTH);
	assign wr_addr = AW'(req.vertex_slot);
	assign wr_data = {req.pos_z, req.pos_y, req.pos_x};
	assign corner  = {req.third_corner, req.second_corner, req.first_corner};

	for (genvar c = 0; c < 3; c++) begin : g_port
		tfn_ram #(
			.WIDTH (VTX_W),
			.DEPTH (VERTEX_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (wr_addr),
			.wdata (wr_data),
			.re    (adv),
			.raddr (AW'(corner[c])),
			.rdata (rd_data[c])
		);

		// out-of-range corners read as the origin
		for (genvar i = 0; i < 3; i++) begin : g_comp
			assign pos[c][i] = oor_s1[c] ? '0 : rd_data[c][i*POS_W +: POS_W];
		end
	end

	// stage 1: table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc && (req.cmd == CMD_TRIANGLE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				oor_s1[c] <= !(32'(corner[c]) < VERTEX_DEPTH);
			end
		end
	end

	tfn_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (vld_s1),
		.pa        (pos[0]),
		.pb        (pos[1]),
		.pc        (pos[2]),
		.valid_out (cr_vld),
		.mag       (cr_mag),
		.neg       (cr_neg)
	);

	tfn_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (cr_vld),
		.mag       (cr_mag),
		.neg       (cr_neg),
		.valid_out (sc_vld),
		.nmag      (sc_nmag),
		.sum       (sc_sum),
		.tag       (sc_tag)
	);

	tfn_sqrt #(
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_in  (sc_vld),
		.radicand  (sc_sum),
		.side_in   ({sc_tag, sc_nmag}),
		.valid_out (sq_vld),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	assign {sq_tag, sq_nmag} = sq_side;

	tfn_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid_in   (sq_vld),
		.nmag       (sq_nmag),
		.root       (sq_root),
		.tag        (sq_tag),
		.valid_out  (dv_vld),
		.nrm        (dv_nrm),
		.degenerate (dv_deg)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_nrm_q <= dv_nrm;
			out_deg_q <= dv_deg;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.normal_x   = out_nrm_q[0];
	assign rsp.normal_y   = out_nrm_q[1];
	assign rsp.normal_z   = out_nrm_q[2];
	assign rsp.degenerate = out_deg_q;

	// degenerate results carry a zero vector
	`TFN_ASSERT_IMP(a_degen_zero, clk, arst_n, rsp.valid && rsp.degenerate, (rsp.normal_x == '0) && (rsp.normal_y == '0) && (rsp.normal_z == '0))
	// a proper triangle always has a nonzero component
	`TFN_ASSERT_IMP(a_normal_nonzero, clk, arst_n, rsp.valid && !rsp.degenerate, (rsp.normal_x != '0) || (rsp.normal_y != '0) || (rsp.normal_z != '0))
	// input is held off only when a result in the last divider slot meets a stalled output
	`TFN_ASSERT_IMP(a_stall_cause, clk, arst_n, !req.ready, out_vld_q && !rsp.ready && dv_vld)
	// a held result is not overwritten while the pipeline is stalled
	`TFN_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_vld_q && !rsp.ready, out_vld_q && $stable(out_nrm_q) && $stable(out_deg_q))
endmodule

/* tb/testbench.sv */
// Testbench of the triangle face normal block: directed table, random meshes, normal predictor
`timescale 1ns / 1ps
module testbench;
	import tfn_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int QUIET_TAIL     = 200;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [NRM_W-1:0] nrm_t;

	typedef struct {
		nrm_t x;
		nrm_t y;
		nrm_t z;
		logic degenerate;
	} face_nrm_t;

	typedef struct {
		logic              cmd;
		logic [SLOT_W-1:0] slot;
		pos_t              px;
		pos_t              py;
		pos_t              pz;
		logic [SLOT_W-1:0] ca;
		logic [SLOT_W-1:0] cb;
		logic [SLOT_W-1:0] cc;
		bit                typed;
		face_nrm_t         want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tfn_req_if req_bus ();
	tfn_rsp_if rsp_bus ();

	triangle_face_normal u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// local copy of the vertex table and the written-slot bookkeeping
	pos_t      vtx_pos[VERTEX_DEPTH_DEF][3];
	bit        vtx_written[VERTEX_DEPTH_DEF];
	int        written_slots[$];
	face_nrm_t normals_due[$];
	int        errors = 0;
	bit        quiet;
	int        idle_pct_tx;
	int        idle_pct_rx;
	int        stall_cycles = 0;

	function automatic longint corner_coord(int unsigned slot, int axis);
		if (slot >= VERTEX_DEPTH_DEF)
			return 0;
		return longint'(vtx_pos[slot][axis]);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned root;
		longint unsigned probe;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > s)
			probe >>= 2;
		while (probe != 0) begin
			if (s >= root + probe) begin
				s    = s - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// cross product of (b - a) and (c - a), scaled to unit length in Q1.14
	function automatic face_nrm_t unit_normal(int unsigned ia, int unsigned ib, int unsigned ic);
		longint          ea[3], eb[3], cr[3];
		longint unsigned mag[3];
		longint unsigned peak, sq_sum, len, q;
		bit              neg[3];
		int              down, up;
		face_nrm_t       r;
		for (int i = 0; i < 3; i++) begin
			ea[i] = corner_coord(ib, i) - corner_coord(ia, i);
			eb[i] = corner_coord(ic, i) - corner_coord(ia, i);
		end
		cr[0] = ea[1] * eb[2] - ea[2] * eb[1];
		cr[1] = ea[2] * eb[0] - ea[0] * eb[2];
		cr[2] = ea[0] * eb[1] - ea[1] * eb[0];
		peak = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i] < 0;
			mag[i] = neg[i] ? longint'(-cr[i]) : longint'(cr[i]);
			if (mag[i] > peak)
				peak = mag[i];
		end
		if (peak == 0) begin
			r.x = '0; r.y = '0; r.z = '0; r.degenerate = 1'b1;
			return r;
		end
		down = 0;
		up   = 0;
		while (peak >= (64'd1 << 31)) begin
			peak >>= 1;
			down++;
		end
		while (peak < (64'd1 << 30)) begin
			peak <<= 1;
			up++;
		end
		sq_sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (mag[i] >> down) << up;
			sq_sum += mag[i] * mag[i];
		end
		len = int_sqrt(sq_sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * 16384 + (len >> 1)) / len;
			if (neg[i])
				q = -q;
			case (i)
				0: r.x = q[15:0];
				1: r.y = q[15:0];
				default: r.z = q[15:0];
			endcase
		end
		r.degenerate = 1'b0;
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles without any beat on either channel
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d normals outstanding", $time, normals_due.size());
			$display("** triangle_face_normal: FAILED **");
			$finish;
		end
	end

	// response side: random stalls, compare each beat with the oldest expected normal
	initial begin
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				rsp_bus.ready = 1'b0;
				stall_cycles--;
			end else if (!quiet && $urandom_range(99) < idle_pct_rx) begin
				rsp_bus.ready = 1'b0;
				stall_cycles  = $urandom_range(17);
			end else begin
				rsp_bus.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		face_nrm_t want;
		if (rsp_bus.valid && rsp_bus.ready) begin
			if (normals_due.size() == 0) begin
				$display("%0t: unexpected normal, expected none, actual %0d %0d %0d deg %0b",
					$time, rsp_bus.normal_x, rsp_bus.normal_y, rsp_bus.normal_z,
					rsp_bus.degenerate);
				errors++;
			end else begin
				want = normals_due.pop_front();
				if (rsp_bus.normal_x !== want.x || rsp_bus.normal_y !== want.y ||
					rsp_bus.normal_z !== want.z || rsp_bus.degenerate !== want.degenerate) begin
					$display("%0t: normal mismatch, expected %0d %0d %0d deg %0b, %s",
						$time, want.x, want.y, want.z, want.degenerate,
						$sformatf("actual %0d %0d %0d deg %0b",
						rsp_bus.normal_x, rsp_bus.normal_y, rsp_bus.normal_z,
						rsp_bus.degenerate));
					errors++;
				end
			end
		end
	end

	// drive one request beat; called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(stim_row_t row);
		int gap;
		if (!quiet && $urandom_range(99) < idle_pct_tx) begin
			req_bus.valid = 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		req_bus.valid         = 1'b1;
		req_bus.cmd           = row.cmd;
		req_bus.vertex_slot   = row.slot;
		req_bus.pos_x         = row.px;
		req_bus.pos_y         = row.py;
		req_bus.pos_z         = row.pz;
		req_bus.first_corner  = row.ca;
		req_bus.second_corner = row.cb;
		req_bus.third_corner  = row.cc;
		do
			@(posedge clk);
		while (!req_bus.ready);
		// beat taken: update the table copy or queue the expected normal
		if (row.cmd == CMD_STORE) begin
			if (row.slot < VERTEX_DEPTH_DEF) begin
				vtx_pos[row.slot][0] = row.px;
				vtx_pos[row.slot][1] = row.py;
				vtx_pos[row.slot][2] = row.pz;
				if (!vtx_written[row.slot]) begin
					vtx_written[row.slot] = 1'b1;
					written_slots.push_back(row.slot);
				end
			end
		end else begin
			normals_due.push_back(row.typed ? row.want : unit_normal(row.ca, row.cb, row.cc));
		end
		@(negedge clk);
		req_bus.valid = 1'b0;
	endtask

	function automatic stim_row_t store_row(int slot, int x, int y, int z);
		stim_row_t r;
		r = '{cmd: CMD_STORE, slot: SLOT_W'(slot), px: pos_t'(x), py: pos_t'(y),
			pz: pos_t'(z), ca: SLOT_W'($urandom), cb: SLOT_W'($urandom),
			cc: SLOT_W'($urandom), typed: 1'b0, want: '{'0, '0, '0, 1'b0}};
		return r;
	endfunction

	function automatic stim_row_t tri_row(int a, int b, int c, bit typed = 0,
		int nx = 0, int ny = 0, int nz = 0, bit deg = 0);
		stim_row_t r;
		r = '{cmd: CMD_TRIANGLE, slot: SLOT_W'($urandom), px: pos_t'($urandom),
			py: pos_t'($urandom), pz: pos_t'($urandom),
			ca: SLOT_W'(a), cb: SLOT_W'(b), cc: SLOT_W'(c), typed: typed,
			want: '{nrm_t'(nx), nrm_t'(ny), nrm_t'(nz), deg}};
		return r;
	endfunction

	function automatic pos_t rand_coord();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1, 2: return pos_t'(int'($urandom_range(8)) - 4);
			3: return pos_t'(int'($urandom_range(2047)) - 1024);
			default: return pos_t'($urandom);
		endcase
	endfunction

	function automatic int pick_corner();
		return written_slots[$urandom_range(written_slots.size() - 1)];
	endfunction

	stim_row_t directed[$];

	initial begin
		stim_row_t row;
		int        a, b, c;
		quiet        = 1'b0;
		idle_pct_tx  = 0;
		idle_pct_rx  = 0;
		arst_n                = 1'b0;
		req_bus.valid         = 1'b0;
		req_bus.cmd           = CMD_STORE;
		req_bus.vertex_slot   = '0;
		req_bus.pos_x         = '0;
		req_bus.pos_y         = '0;
		req_bus.pos_z         = '0;
		req_bus.first_corner  = '0;
		req_bus.second_corner = '0;
		req_bus.third_corner  = '0;

		// directed table; typed rows carry a normal that follows directly from the geometry
		directed.push_back(store_row(0, 0, 0, 0));
		directed.push_back(store_row(1, 256, 0, 0));
		directed.push_back(store_row(2, 0, 256, 0));
		directed.push_back(tri_row(0, 1, 2, 1, 0, 0, 16384, 0));
		directed.push_back(tri_row(0, 2, 1, 1, 0, 0, -16384, 0));
		directed.push_back(tri_row(1, 1, 1, 1, 0, 0, 0, 1));
		directed.push_back(tri_row(0, 0, 2, 1, 0, 0, 0, 1));
		directed.push_back(store_row(4, 1, 0, 0));
		directed.push_back(store_row(5, 0, 0, 1));
		directed.push_back(tri_row(0, 4, 5, 1, 0, -16384, 0, 0));
		directed.push_back(store_row(255, 32767, 32767, 32767));
		directed.push_back(store_row(254, -32768, -32768, -32768));
		directed.push_back(store_row(3, -32768, 32767, 0));
		directed.push_back(store_row(6, 32767, -32768, 1));
		directed.push_back(tri_row(254, 255, 3));
		directed.push_back(tri_row(255, 254, 3));
		directed.push_back(tri_row(6, 255, 254));
		directed.push_back(tri_row(3, 6, 254));
		directed.push_back(tri_row(254, 255, 0, 1, 0, 0, 0, 1));
		directed.push_back(store_row(7, -1, -1, -1));
		directed.push_back(tri_row(7, 4, 2));
		directed.push_back(tri_row(2, 7, 255));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_beat(directed[i]);

		// random mesh traffic; triangles use written corners only, some repeat one
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				idle_pct_tx = ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
				idle_pct_rx = ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
			end
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until the pipeline has drained completely
				while (normals_due.size() != 0)
					@(negedge clk);
			end
			if (n >= RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if ($urandom_range(99) < 40) begin
				row = store_row($urandom_range(255), rand_coord(), rand_coord(), rand_coord());
			end else begin
				a = pick_corner();
				b = pick_corner();
				c = pick_corner();
				case ($urandom_range(9))
					0: b = a;
					1: c = b;
					default: ;
				endcase
				row = tri_row(a, b, c);
			end
			send_beat(row);
		end

		while (normals_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("** triangle_face_normal: PASSED **");
		else
			$display("** triangle_face_normal: FAILED **");
		$finish;
	end
endmodule
